// ===== rtl/core/lvct_pkg.sv =====
`default_nettype none

package lvct_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int STAMP_WIDTH = 64;

    // Opcode carried on tuser
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_MERGE = 1'b1;

    typedef logic [VALUE_WIDTH-1:0]        value_t;
    typedef logic signed [STAMP_WIDTH-1:0] stamp_t;

    // Tracker state: previous value and its last stamp, current value with
    // its first and last stamps, and the seen flag.
    typedef struct packed {
        value_t pv;
        stamp_t pl;
        value_t cv;
        stamp_t cf;
        stamp_t cl;
        logic   seen;
    } track_t;

    // One input item after width trimming
    typedef struct packed {
        logic   op;
        value_t value;
        stamp_t stamp;
        track_t part;
    } item_t;

endpackage

`default_nettype wire

// ===== rtl/core/lvct_fold.sv =====
`default_nettype none

// Next-state logic: applies one add or merge item to the stored state.
module lvct_fold (
    input  wire lvct_pkg::track_t state_i,
    input  wire lvct_pkg::item_t  item_i,
    output lvct_pkg::track_t      state_o,
    output logic signed [63:0]    lca_o
);

    function automatic logic slt(input lvct_pkg::stamp_t x, input lvct_pkg::stamp_t y);
        return $signed(x) < $signed(y);
    endfunction

    // l ends before r starts, with the tie rules
    function automatic logic earlier(input lvct_pkg::track_t l, input lvct_pkg::track_t r);
        logic res;
        res = slt(l.cf, r.pl) ||
              ((l.cf == r.pl) && (slt(l.cf, r.cf) || slt(l.pl, r.pl)));
        return res;
    endfunction

    lvct_pkg::track_t a;
    lvct_pkg::track_t b;
    lvct_pkg::track_t nxt;
    lvct_pkg::track_t lt;
    lvct_pkg::track_t et;
    lvct_pkg::value_t v;
    lvct_pkg::stamp_t t;
    logic             ab_early;
    logic             ba_early;
    logic             b_later;
    logic             ext;

    assign a        = state_i;
    assign b        = item_i.part;
    assign v        = item_i.value;
    assign t        = item_i.stamp;
    assign ab_early = earlier(a, b);
    assign ba_early = earlier(b, a);
    assign b_later  = !slt(b.cf, a.cf);
    assign lt       = b_later ? b : a;
    assign et       = b_later ? a : b;

    always_comb begin
        nxt = a;
        ext = 1'b0;
        priority if (item_i.op == lvct_pkg::OP_ADD) begin
            priority if (!a.seen) begin
                nxt.pv   = v;
                nxt.pl   = t;
                nxt.cv   = v;
                nxt.cf   = t;
                nxt.cl   = t;
                nxt.seen = 1'b1;
            end else if (v != a.cv) begin
                nxt.pv = a.cv;
                nxt.pl = a.cl;
                nxt.cv = v;
                nxt.cf = t;
                nxt.cl = t;
            end else begin
                nxt.cl = t;
            end
        end else if (!b.seen) begin
            nxt = a;
        end else if (!a.seen) begin
            nxt = b;
        end else if (ab_early) begin
            // stored range lies wholly before the part
            priority if (b.pv != b.cv) begin
                nxt = b;
            end else if (a.cv != b.pv) begin
                nxt.pv = a.cv;
                nxt.pl = a.cl;
                nxt.cv = b.pv;
                nxt.cf = b.pl;
                nxt.cl = b.cl;
            end else begin
                if (a.pv == a.cv) begin
                    if (slt(b.pl, a.pl)) nxt.pl = b.pl;
                    if (slt(a.cf, b.cf)) nxt.cf = b.cf;
                end
                if (slt(a.cl, b.cl)) nxt.cl = b.cl;
            end
        end else if (ba_early) begin
            // part lies wholly before the stored range
            priority if (a.pv != a.cv) begin
                nxt = a;
            end else if (b.cv != a.pv) begin
                nxt.cv = a.pv;
                nxt.cf = a.pl;
                nxt.pv = b.cv;
                nxt.pl = b.cl;
            end else if (b.pv != b.cv) begin
                nxt    = b;
                nxt.cl = slt(b.cl, a.cl) ? a.cl : b.cl;
            end else begin
                if (slt(b.pl, a.pl)) nxt.pl = b.pl;
                if (slt(a.cf, b.cf)) nxt.cf = b.cf;
                if (slt(a.cl, b.cl)) nxt.cl = b.cl;
            end
        end else begin
            // overlapping ranges: lt is the one starting later
            if (slt(lt.pl, et.pl)) begin
                // earlier range contained in the later one
                priority if (lt.cv != et.cv) begin
                    nxt.pv = et.cv; nxt.cv = lt.cv;
                    nxt.pl = et.cl; nxt.cf = lt.cf; nxt.cl = lt.cl;
                end else if (lt.cv != et.pv) begin
                    nxt.pv = et.pv; nxt.cv = lt.cv;
                    nxt.pl = et.pl; nxt.cf = et.cf; nxt.cl = lt.cl; ext = 1'b1;
                end else if (lt.pv != et.pv) begin
                    nxt.pv = lt.pv; nxt.cv = et.pv;
                    nxt.pl = lt.pl; nxt.cf = et.pl; nxt.cl = lt.cl; ext = 1'b1;
                end else begin
                    nxt.pv = lt.pv; nxt.cv = lt.cv;
                    nxt.pl = lt.cl; nxt.cf = lt.cf; nxt.cl = lt.cl; ext = 1'b1;
                end
            end else begin
                // ranges intersect
                priority if (lt.cv != et.cv) begin
                    nxt.pv = et.cv; nxt.cv = lt.cv;
                    nxt.pl = et.cl; nxt.cf = lt.cf; nxt.cl = lt.cl;
                end else if (lt.cv != lt.pv) begin
                    nxt.pv = lt.pv; nxt.cv = lt.cv;
                    nxt.pl = lt.pl; nxt.cf = et.cf; nxt.cl = lt.cl; ext = 1'b1;
                end else if (lt.pv != et.pv) begin
                    nxt.pv = et.pv; nxt.cv = lt.pv;
                    nxt.pl = et.pl; nxt.cf = lt.pl; nxt.cl = lt.cl; ext = 1'b1;
                end else begin
                    nxt.pv = lt.pv; nxt.cv = lt.cv;
                    nxt.pl = lt.cl; nxt.cf = lt.cf; nxt.cl = lt.cl; ext = 1'b1;
                end
            end
            if (ext && slt(lt.cl, et.cl)) nxt.cl = et.cl;
            nxt.seen = a.seen;
        end
    end

    assign state_o = nxt;
    assign lca_o   = 64'($signed((nxt.pv == nxt.cv) ? nxt.pl : nxt.cf));

endmodule

`default_nettype wire

// ===== rtl/core/last_value_change_tracker_unit.sv =====
// Last value change tracker.
// Slave channel (s_*): one item per transfer. s_tuser is the opcode: add one
// observation (value, stamp) or merge a partial tracker state (part_* fields).
// Master channel (m_*): exactly one result per accepted item, in order:
// the change stamp (signed) and has_data.
// Flow: an accepted item is held in the input register; when the result
// register is free or being drained, the item runs through the fold logic,
// which updates the state and loads the result register, and m_tvalid rises
// with that load. Throughput is one item per cycle while m_tready stays high;
// the limit is the loop from the state registers through the fold
// compare/select logic back to the state.
// Stall: while m_tready is low the result register holds, one further item
// may wait in the input register, and s_tready drops only when both are full.
// s_tready depends combinationally on m_tready.
// Reset (aresetn low, synchronous): both stages empty, tracker state cleared
// to zero with has_data low. A result with no data reports time zero.
// Value bits above VALUE_WIDTH are ignored; stamps are taken from their low
// STAMP_WIDTH bits and sign-extended.
`default_nettype none

module last_value_change_tracker_unit (
    input  wire         aclk,
    input  wire         aresetn,
    // slave channel
    input  wire         s_tvalid,
    output logic        s_tready,
    // tdata, lowest bit up: value[64], stamp[64], part_prev_value[64],
    // part_prev_last_ts[64], part_cur_value[64], part_cur_first_ts[64],
    // part_cur_last_ts[64], part_seen[1], zero pad[7]
    input  wire [455:0] s_tdata,
    // tuser: op[1]
    input  wire         s_tuser,
    // master channel
    output logic        m_tvalid,
    input  wire         m_tready,
    // tdata, lowest bit up: change_stamp[64], has_data[1], zero pad[7]
    output logic [71:0] m_tdata
);

    lvct_pkg::item_t  s_item;
    lvct_pkg::item_t  in_item_reg;
    logic             in_valid_reg;
    lvct_pkg::track_t state_reg;
    lvct_pkg::track_t state_next;
    logic signed [63:0] lca_next;
    logic signed [63:0] res_lca_reg;
    logic             res_has_reg;
    logic             m_valid_reg;
    logic             advance;

    // Unpack the slave transfer, trimming to the configured widths
    always_comb begin
        s_item.op        = s_tuser;
        s_item.value     = lvct_pkg::value_t'(s_tdata[63:0]);
        s_item.stamp     = lvct_pkg::stamp_t'(s_tdata[127:64]);
        s_item.part.pv   = lvct_pkg::value_t'(s_tdata[191:128]);
        s_item.part.pl   = lvct_pkg::stamp_t'(s_tdata[255:192]);
        s_item.part.cv   = lvct_pkg::value_t'(s_tdata[319:256]);
        s_item.part.cf   = lvct_pkg::stamp_t'(s_tdata[383:320]);
        s_item.part.cl   = lvct_pkg::stamp_t'(s_tdata[447:384]);
        s_item.part.seen = s_tdata[448];
    end

    // Input stage moves on when the result register is free or being drained
    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_item_reg <= s_item;
        end
    end

    lvct_fold u_fold (
        .state_i (state_reg),
        .item_i  (in_item_reg),
        .state_o (state_next),
        .lca_o   (lca_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (advance) begin
            res_lca_reg <= lca_next;
            res_has_reg <= state_next.seen;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, res_has_reg, res_lca_reg};

`ifndef SYNTHESIS
    // Once data is absorbed the tracker never becomes empty again
    a_seen_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.seen |=> state_reg.seen)
        else $error("tracker lost its seen flag");

    // An empty tracker always reports time zero
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !res_has_reg |-> res_lca_reg == 64'sd0)
        else $error("empty result with nonzero timestamp");

    // A processed item always leaves a result behind
    a_advance_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("processed item produced no result");

    // A held input item is not dropped
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("waiting input item lost");
`endif

endmodule

`default_nettype wire
